@@ design/transition_matrix_estimator_assert.svh @@
// assertion macros shared by the transition matrix estimator modules
// expects clk and arst_n in the scope of each use
`ifndef TRANSITION_MATRIX_ESTIMATOR_ASSERT_SVH
`define TRANSITION_MATRIX_ESTIMATOR_ASSERT_SVH

// consequent checked in the same cycle
`define TME_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define TME_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/tme_pkg.sv @@
// shared types and constants of the transition matrix estimator
// no dependencies
package tme_pkg;

	localparam int SYM_FIELD_W = 3;
	localparam int Q_W         = 17;
	localparam int Q_FRAC      = 16;
	localparam int STEP_W      = 5;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 24;

	typedef enum logic [2:0] {
		PS_IDLE,
		PS_RD_SUM,
		PS_ACC_SUM,
		PS_RD_DIV,
		PS_START_DIV,
		PS_DIV
	} pass_state_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr;
	} ram_ctrl_t;

endpackage

@@ design/tme_count_ram.sv @@
// pair count memory with registered read and per-entry valid bits
// depends on tme_pkg and transition_matrix_estimator_assert.svh
`include "transition_matrix_estimator_assert.svh"

module tme_count_ram #(
	parameter int COUNT_BITS = 16,
	parameter int CELLS      = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tme_pkg::ram_ctrl_t           ctrl,
	input  logic [$clog2(CELLS)-1:0]     rd_addr,
	input  logic [$clog2(CELLS)-1:0]     wr_addr,
	input  logic [COUNT_BITS-1:0]        wr_data,
	output logic [COUNT_BITS-1:0]        rd_data
);

	logic [COUNT_BITS-1:0] mem [CELLS];
	logic [COUNT_BITS-1:0] rdata_q;
	logic                  rd_vld_q;
	logic [CELLS-1:0]      vld_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctrl.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctrl.rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
			if (ctrl.clr) begin
				vld_q <= '0;
			end else if (ctrl.wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	// unwritten entries read as zero
	assign rd_data = rd_vld_q ? rdata_q : '0;

	`TME_ASSERT_NEXT(a_clear_empties, ctrl.clr, vld_q == '0, "matrix not empty after clear")

endmodule

@@ design/tme_div.sv @@
// restoring divider, one quotient bit per cycle: (count*65536 + sum/2) / sum
// depends on tme_pkg and transition_matrix_estimator_assert.svh
`include "transition_matrix_estimator_assert.svh"

module tme_div #(
	parameter int COUNT_BITS = 16,
	parameter int SUM_W      = 19
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [COUNT_BITS-1:0]     count,
	input  logic [SUM_W-1:0]          sum,
	output logic                      done,
	output logic [tme_pkg::Q_W-1:0]   quot
);

	localparam int QW   = tme_pkg::Q_W;
	localparam int QF   = tme_pkg::Q_FRAC;
	localparam int SW   = tme_pkg::STEP_W;
	localparam int D_W  = COUNT_BITS + QW;

	logic [D_W-1:0]   dividend;
	logic [SUM_W-1:0] rem_q;
	logic [SUM_W-1:0] div_q;
	logic [QW-1:0]    sh_q;
	logic [SW-1:0]    step_q;
	logic             busy_q;
	logic             done_q;
	logic [SUM_W:0]   trial;
	logic             ge;

	assign dividend = D_W'({count, {QF{1'b0}}}) + D_W'(sum >> 1);
	assign trial    = {rem_q, sh_q[QW-1]};
	assign ge       = trial >= {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= SUM_W'(dividend[D_W-1:QW]);
			sh_q  <= dividend[QW-1:0];
			div_q <= sum;
		end else if (busy_q) begin
			rem_q <= ge ? SUM_W'(trial - {1'b0, div_q}) : SUM_W'(trial);
			sh_q  <= {sh_q[QW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == SW'(QW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign quot = sh_q;

	`TME_ASSERT_NEXT(a_start_restarts, start, busy_q && !done_q, "divider did not restart")

endmodule

@@ design/transition_matrix_estimator.sv @@
// top level of the transition matrix estimator: symbol update pipeline and finish pass
// depends on tme_pkg, tme_count_ram, tme_div and transition_matrix_estimator_assert.svh
//
// input channel s_axis: tuser is the mode (0 symbol, 1 finish), tdata holds the symbol
// and its found flag. symbol transactions are taken one per cycle while no pass runs; each
// counted pair goes through a read-modify-write of the count memory (read, then increment
// and write in the following cycle, with forwarding from the previous write). symbol
// transactions give no output. a finish transaction starts a pass over the matrix during
// which s_axis_tready is low. per row the pass first reads the NUM_SYMBOLS counts to form
// the row sum, then per entry reads the count and runs the bit-serial divider.
// output channel m_axis: tdata holds row, column and Q1.16 probability, tlast marks the final
// entry. results sit in an output register; when the receiver stalls, the pass waits with
// the next entry in the divider. at the end of the pass the matrix and the previous symbol
// are cleared and s_axis_tready rises again.
// reset clears the valid bits of the count memory at once, so no clearing sweep is needed.
`include "transition_matrix_estimator_assert.svh"

module transition_matrix_estimator #(
	parameter int NUM_SYMBOLS = 8,
	parameter int COUNT_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [tme_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // symbol, symbol_found
	input  logic [0:0]                          s_axis_tuser,  // mode
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [tme_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // row_index, col_index, probability
	output logic                                m_axis_tlast
);

	localparam int SFW    = tme_pkg::SYM_FIELD_W;
	localparam int QW     = tme_pkg::Q_W;
	localparam int SYM_W  = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
	localparam int CELLS  = NUM_SYMBOLS * NUM_SYMBOLS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int SUM_W  = COUNT_BITS + SYM_W;
	localparam int PAD_W  = tme_pkg::OUT_TDATA_W - 2 * SFW - QW;
	localparam logic [SFW:0]            SYM_LIMIT = (SFW + 1)'(NUM_SYMBOLS);
	localparam logic [SYM_W-1:0]        IDX_LAST  = SYM_W'(NUM_SYMBOLS - 1);
	localparam logic [COUNT_BITS-1:0]   COUNT_MAX = '1;

	tme_pkg::pass_state_t state_q, state_d;
	tme_pkg::ram_ctrl_t   ram_ctrl;

	logic                  in_acc;
	logic                  mode;
	logic [SFW-1:0]        sym;
	logic                  sym_ok;
	logic [SYM_W-1:0]      sym_idx;
	logic                  count_hit;
	logic [ADDR_W-1:0]     pair_addr;
	logic [ADDR_W-1:0]     pass_addr;
	logic [ADDR_W-1:0]     rd_addr;
	logic [COUNT_BITS-1:0] rd_data;

	logic [SYM_W-1:0]      prev_sym_q;
	logic                  prev_found_q;

	logic                  inc_vld_s1;
	logic [ADDR_W-1:0]     addr_s1;
	logic                  wr_vld_q;
	logic [ADDR_W-1:0]     wr_addr_q;
	logic [COUNT_BITS-1:0] wr_data_q;
	logic [COUNT_BITS-1:0] cnt_cur;
	logic [COUNT_BITS-1:0] cnt_nxt;

	logic [SYM_W-1:0]      row_q;
	logic [SYM_W-1:0]      col_q;
	logic [SUM_W-1:0]      sum_q;
	logic                  col_last;
	logic                  row_last;
	logic                  pass_rd;
	logic                  sum_acc;
	logic                  div_start;
	logic                  div_done;
	logic [QW-1:0]         quot;
	logic                  emit;
	logic                  clr;
	logic                  out_free;

	logic                  m_tvalid_q;
	logic [SFW-1:0]        out_row_q;
	logic [SFW-1:0]        out_col_q;
	logic [QW-1:0]         out_prob_q;
	logic                  out_last_q;

	// input decode
	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign mode      = s_axis_tuser[0];
	assign sym       = s_axis_tdata[SFW-1:0];
	assign sym_ok    = s_axis_tdata[SFW] && ({1'b0, sym} < SYM_LIMIT);
	assign sym_idx   = sym[SYM_W-1:0];
	assign count_hit = in_acc && !mode && sym_ok && prev_found_q;
	assign pair_addr = ADDR_W'(ADDR_W'(prev_sym_q) * ADDR_W'(NUM_SYMBOLS) + ADDR_W'(sym_idx));
	assign pass_addr = ADDR_W'(ADDR_W'(row_q) * ADDR_W'(NUM_SYMBOLS) + ADDR_W'(col_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sym_q   <= '0;
			prev_found_q <= 1'b0;
		end else if (clr) begin
			prev_sym_q   <= '0;
			prev_found_q <= 1'b0;
		end else if (in_acc && !mode) begin
			prev_sym_q   <= sym_idx;
			prev_found_q <= sym_ok;
		end
	end

	// read-modify-write of the pair counts
	assign cnt_cur = (wr_vld_q && (wr_addr_q == addr_s1)) ? wr_data_q : rd_data;
	assign cnt_nxt = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_vld_s1 <= 1'b0;
			wr_vld_q   <= 1'b0;
		end else begin
			inc_vld_s1 <= count_hit;
			wr_vld_q   <= inc_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (count_hit) begin
			addr_s1 <= pair_addr;
		end
		if (inc_vld_s1) begin
			wr_addr_q <= addr_s1;
			wr_data_q <= cnt_nxt;
		end
	end

	assign rd_addr        = (state_q == tme_pkg::PS_IDLE) ? pair_addr : pass_addr;
	assign ram_ctrl.rd_en = count_hit || pass_rd;
	assign ram_ctrl.wr_en = inc_vld_s1;
	assign ram_ctrl.clr   = clr;

	tme_count_ram #(
		.COUNT_BITS (COUNT_BITS),
		.CELLS      (CELLS)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ram_ctrl),
		.rd_addr (rd_addr),
		.wr_addr (addr_s1),
		.wr_data (cnt_nxt),
		.rd_data (rd_data)
	);

	tme_div #(
		.COUNT_BITS (COUNT_BITS),
		.SUM_W      (SUM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.count  (rd_data),
		.sum    (sum_q),
		.done   (div_done),
		.quot   (quot)
	);

	// finish pass control
	assign col_last = col_q == IDX_LAST;
	assign row_last = row_q == IDX_LAST;
	assign out_free = !m_tvalid_q || m_axis_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tme_pkg::PS_IDLE: begin
				if (in_acc && mode) begin
					state_d = tme_pkg::PS_RD_SUM;
				end
			end
			tme_pkg::PS_RD_SUM:    state_d = tme_pkg::PS_ACC_SUM;
			tme_pkg::PS_ACC_SUM:   state_d = col_last ? tme_pkg::PS_RD_DIV : tme_pkg::PS_RD_SUM;
			tme_pkg::PS_RD_DIV:    state_d = tme_pkg::PS_START_DIV;
			tme_pkg::PS_START_DIV: state_d = tme_pkg::PS_DIV;
			tme_pkg::PS_DIV: begin
				if (div_done && out_free) begin
					if (!col_last) begin
						state_d = tme_pkg::PS_RD_DIV;
					end else if (row_last) begin
						state_d = tme_pkg::PS_IDLE;
					end else begin
						state_d = tme_pkg::PS_RD_SUM;
					end
				end
			end
			default:               state_d = tme_pkg::PS_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		pass_rd       = 1'b0;
		sum_acc       = 1'b0;
		div_start     = 1'b0;
		emit          = 1'b0;
		unique case (state_q)
			tme_pkg::PS_IDLE:      s_axis_tready = 1'b1;
			tme_pkg::PS_RD_SUM:    pass_rd       = 1'b1;
			tme_pkg::PS_ACC_SUM:   sum_acc       = 1'b1;
			tme_pkg::PS_RD_DIV:    pass_rd       = 1'b1;
			tme_pkg::PS_START_DIV: div_start     = 1'b1;
			tme_pkg::PS_DIV:       emit          = div_done && out_free;
			default:               s_axis_tready = 1'b0;
		endcase
	end

	assign clr = emit && col_last && row_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tme_pkg::PS_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			sum_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == tme_pkg::PS_IDLE) begin
				row_q <= '0;
				col_q <= '0;
				sum_q <= '0;
			end else if (sum_acc) begin
				sum_q <= sum_q + SUM_W'(rd_data);
				col_q <= col_last ? '0 : col_q + 1'b1;
			end else if (emit) begin
				if (col_last) begin
					col_q <= '0;
					row_q <= row_last ? '0 : row_q + 1'b1;
					sum_q <= '0;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_row_q  <= SFW'(row_q);
			out_col_q  <= SFW'(col_q);
			out_prob_q <= (sum_q == '0) ? '0 : quot;
			out_last_q <= col_last && row_last;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, out_prob_q, out_col_q, out_row_q};
	assign m_axis_tlast  = out_last_q;

	`TME_ASSERT_IMPL(a_no_update_in_pass, inc_vld_s1, state_q == tme_pkg::PS_IDLE, "count update during pass")
	`TME_ASSERT_NEXT(a_finish_starts_pass, in_acc && mode, state_q == tme_pkg::PS_RD_SUM, "finish did not start pass")
	`TME_ASSERT_NEXT(a_clear_ends_pass, clr, s_axis_tready && !prev_found_q, "pass end did not clear")

endmodule

@@ tb/transition_matrix_estimator_tb.sv @@
// testbench for transition_matrix_estimator: symbol streams and finish passes with random idling
// keeps its own transition count matrix to predict each normalized matrix entry
// depends on tme_pkg and the transition_matrix_estimator rtl
module transition_matrix_estimator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_SYMBOLS = 8;
	localparam int COUNT_BITS  = 16;
	localparam int CELLS       = NUM_SYMBOLS * NUM_SYMBOLS;
	localparam int SFW         = tme_pkg::SYM_FIELD_W;
	localparam int QW          = tme_pkg::Q_W;
	localparam int QF          = tme_pkg::Q_FRAC;
	localparam int IN_W        = tme_pkg::IN_TDATA_W;
	localparam int OUT_W       = tme_pkg::OUT_TDATA_W;
	localparam logic MODE_SYMBOL = 1'b0;
	localparam logic MODE_FINISH = 1'b1;

	typedef struct packed {
		logic [SFW-1:0] row;
		logic [SFW-1:0] col;
		logic [QW-1:0]  prob;
		logic           last;
	} matrix_entry_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata;
	logic [0:0]        s_axis_tuser;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [OUT_W-1:0]  m_axis_tdata;
	logic              m_axis_tlast;

	logic [COUNT_BITS-1:0] transition_counts [CELLS];
	logic [SFW-1:0]        prev_symbol;
	logic                  prev_found;
	matrix_entry_t         expected_entries [$];
	matrix_entry_t         want_entry;
	int                    error_count;
	bit                    send_idle_on;
	bit                    recv_idle_on;

	transition_matrix_estimator #(
		.NUM_SYMBOLS(NUM_SYMBOLS),
		.COUNT_BITS (COUNT_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("transition_matrix_estimator_tb: errors");
		$finish;
	end

	task automatic clear_matrix_model();
		for (int i = 0; i < CELLS; i++) transition_counts[i] = '0;
		prev_symbol = '0;
		prev_found  = 1'b0;
	endtask

	task automatic update_transition_model(input logic mode, input logic [2:0] sym,
			input logic found);
		int            idx;
		longint        row_sum;
		longint        cnt;
		matrix_entry_t entry;
		if (mode == MODE_SYMBOL) begin
			if (sym >= NUM_SYMBOLS) found = 1'b0;
			if (found && prev_found) begin
				idx = prev_symbol * NUM_SYMBOLS + sym;
				if (transition_counts[idx] != '1) transition_counts[idx]++;
			end
			prev_symbol = sym;
			prev_found  = found;
		end else begin
			for (int r = 0; r < NUM_SYMBOLS; r++) begin
				row_sum = 0;
				for (int c = 0; c < NUM_SYMBOLS; c++)
					row_sum += transition_counts[r * NUM_SYMBOLS + c];
				for (int c = 0; c < NUM_SYMBOLS; c++) begin
					cnt = transition_counts[r * NUM_SYMBOLS + c];
					entry.row  = SFW'(r);
					entry.col  = SFW'(c);
					entry.prob = (row_sum == 0) ? '0 :
						QW'((cnt * (longint'(1) << QF) + row_sum / 2) / row_sum);
					entry.last = (r * NUM_SYMBOLS + c == CELLS - 1);
					expected_entries.push_back(entry);
				end
			end
			clear_matrix_model();
		end
	endtask

	// called right after a rising edge; leaves tvalid high after the transaction
	task automatic send_item(input logic mode, input logic [2:0] sym, input logic found);
		int gap;
		gap = send_idle_on ? $urandom_range(19, 0) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= {{(IN_W - 4){1'b0}}, found, sym};
		do @(posedge clk); while (!s_axis_tready);
		update_transition_model(mode, sym, found);
	endtask

	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (expected_entries.size() != 0);
	endtask

	task automatic report_mismatch(input string field, input int want, input int got);
		error_count++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
	endtask

	initial begin
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			int stall;
			stall = recv_idle_on ? $urandom_range(19, 0) : 0;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_entries.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result, expected none, actual tdata %h tlast %b",
					$time, m_axis_tdata, m_axis_tlast);
			end else begin
				want_entry = expected_entries.pop_front();
				if (m_axis_tdata[2:0] !== want_entry.row)
					report_mismatch("row_index", int'(want_entry.row),
						int'(m_axis_tdata[2:0]));
				if (m_axis_tdata[5:3] !== want_entry.col)
					report_mismatch("col_index", int'(want_entry.col),
						int'(m_axis_tdata[5:3]));
				if (m_axis_tdata[22:6] !== want_entry.prob)
					report_mismatch("probability", int'(want_entry.prob),
						int'(m_axis_tdata[22:6]));
				if (m_axis_tlast !== want_entry.last)
					report_mismatch("last", int'(want_entry.last), int'(m_axis_tlast));
			end
		end
	end

	task automatic test_empty_stream();
		send_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		send_item(MODE_FINISH, 3'd7, 1'b1);
		wait_results_drained();
	endtask

	// broken pairs, extreme symbols, single-entry rows and clearing by finish
	task automatic test_directed_sequences();
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
		send_item(MODE_SYMBOL, 3'd0, 1'b1);
		send_item(MODE_SYMBOL, 3'd0, 1'b1);
		send_item(MODE_SYMBOL, 3'd7, 1'b1);
		send_item(MODE_SYMBOL, 3'd7, 1'b0);
		send_item(MODE_SYMBOL, 3'd2, 1'b1);
		send_item(MODE_SYMBOL, 3'd2, 1'b1);
		send_item(MODE_SYMBOL, 3'd5, 1'b0);
		send_item(MODE_SYMBOL, 3'd5, 1'b0);
		send_item(MODE_SYMBOL, 3'd6, 1'b1);
		send_item(MODE_SYMBOL, 3'd7, 1'b1);
		send_item(MODE_SYMBOL, 3'd0, 1'b1);
		send_item(MODE_SYMBOL, 3'd1, 1'b1);
		send_item(MODE_SYMBOL, 3'd4, 1'b0);
		send_item(MODE_FINISH, 3'd0, 1'b0);
		send_item(MODE_SYMBOL, 3'd4, 1'b1);
		send_item(MODE_SYMBOL, 3'd6, 1'b1);
		send_item(MODE_SYMBOL, 3'd6, 1'b1);
		send_item(MODE_SYMBOL, 3'd3, 1'b1);
		send_item(MODE_FINISH, 3'd5, 1'b1);
		wait_results_drained();
	endtask

	task automatic test_random_streams();
		int max_sym;
		for (int phase = 0; phase < 6; phase++) begin
			send_idle_on = (phase == 2) ? 1'b0 : 1'($urandom_range(1, 0));
			recv_idle_on = (phase == 2) ? 1'b0 : 1'($urandom_range(1, 0));
			max_sym = (phase % 2 == 0) ? 7 : int'($urandom_range(7, 1));
			repeat (55) begin
				if ($urandom_range(24, 0) == 0)
					send_item(MODE_FINISH, 3'($urandom), 1'($urandom));
				else
					send_item(MODE_SYMBOL, 3'($urandom_range(max_sym, 0)),
						$urandom_range(9, 0) != 0);
			end
			send_item(MODE_FINISH, 3'($urandom), 1'($urandom));
			wait_results_drained();
		end
	endtask

	initial begin
		error_count   = 0;
		send_idle_on  = 1'b0;
		recv_idle_on  = 1'b0;
		clear_matrix_model();
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= MODE_SYMBOL;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_stream();
		test_directed_sequences();
		test_random_streams();

		wait_results_drained();
		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("transition_matrix_estimator_tb: clean");
		else
			$display("transition_matrix_estimator_tb: errors");
		$finish;
	end

endmodule

@@ transition_matrix_estimator.f @@
+incdir+design
design/tme_pkg.sv
design/tme_count_ram.sv
design/tme_div.sv
design/transition_matrix_estimator.sv
tb/transition_matrix_estimator_tb.sv
